@@ rtl/cdq_pkg.sv @@
package cdq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int WORD_W    = 32;
    localparam int CAP_W     = 5;
    localparam int CMD_W     = 3;
    localparam int STAT_W    = 2;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef logic [WORD_W-1:0] t_word;

    localparam t_word NO_WORD = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_REAR  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_REAR   = 3'd3,
        CMD_PEEK_FRONT = 3'd4,
        CMD_PEEK_REAR  = 3'd5
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Broadcast to all cells; at most one push/pop bit, plus clear.
    typedef struct packed {
        logic push_front;
        logic push_rear;
        logic pop_front;
        logic pop_rear;
        logic clear;
    } t_cell_ctl;

endpackage

@@ rtl/cdq_cell.sv @@
module cdq_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cdq_pkg::t_cell_ctl  i_ctl,
    input  cdq_pkg::t_word      i_value,
    input  cdq_pkg::t_word      i_left_data,
    input  logic                i_left_valid,
    input  cdq_pkg::t_word      i_right_data,
    input  logic                i_right_valid,
    output cdq_pkg::t_word      o_data,
    output logic                o_valid,
    output cdq_pkg::t_word      o_rear_tap
);
    import cdq_pkg::*;

    t_word r_data;
    t_word n_data;
    logic  r_valid;
    logic  n_valid;

    always_comb begin
        n_data  = r_data;
        n_valid = r_valid;
        if (i_ctl.clear) begin
            n_valid = 1'b0;
        end else if (i_ctl.push_front) begin
            n_data  = i_left_data;
            n_valid = i_left_valid;
        end else if (i_ctl.push_rear) begin
            // The first empty cell after the occupied run takes the word.
            if (!r_valid && i_left_valid) begin
                n_data  = i_value;
                n_valid = 1'b1;
            end
        end else if (i_ctl.pop_front) begin
            n_data  = i_right_data;
            n_valid = i_right_valid;
        end else if (i_ctl.pop_rear) begin
            n_valid = r_valid & i_right_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data     = r_data;
    assign o_valid    = r_valid;
    assign o_rear_tap = (r_valid && !i_right_valid) ? r_data : '0;

endmodule

@@ rtl/circular_deque_core.sv @@
// Channel     Direction  tdata                tuser
// s_axis      in         value[31:0]          command[2:0]
// m_axis      out        data[31:0]           status[1:0], now_empty[2], now_full[3]
// cfg         in         capacity[4:0] on i_cfg_wen, no handshake
//
// One request per cycle while s_axis is not stalled; its result appears on m_axis the cycle after acceptance.
// The front word sits in cell 0 and the rear word is picked from the last occupied
// cell, so each push or pop is one shift or one cell write across the row of cells.
// Reset empties the deque and sets capacity to 16; a capacity write empties it too.
// s_axis stalls only while a result is held and m_axis is not ready.
module circular_deque_core #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wen,
    input  logic [cdq_pkg::CAP_W-1:0]   i_cfg_wdata,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [31:0]                 i_s_axis_tdata,  // value[31:0]
    input  logic [2:0]                  i_s_axis_tuser,  // command[2:0]
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [31:0]                 o_m_axis_tdata,  // data[31:0]
    output logic [3:0]                  o_m_axis_tuser   // status[1:0], now_empty, now_full
);
    import cdq_pkg::*;

    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

    logic [CAP_W-1:0] r_capacity;
    logic [OCC_W-1:0] r_occ;
    logic [OCC_W-1:0] n_occ;

    logic             r_out_valid;
    t_word            r_out_data;
    t_status          r_out_status;
    logic             r_out_empty;
    logic             r_out_full;

    t_word            cell_data  [DEPTH];
    logic             cell_valid [DEPTH];
    t_word            cell_tap   [DEPTH];
    t_cell_ctl        ctl;

    logic             accept;
    t_cmd             cmd;
    logic [CMP_W-1:0] cap_eff;
    logic [CMP_W-1:0] occ_ext;
    logic [CMP_W-1:0] n_occ_ext;
    logic             is_empty;
    logic             is_full;
    t_word            rear_word;
    t_word            res_data;
    t_status          res_status;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign cmd             = t_cmd'(i_s_axis_tuser);

    // Capacity of zero acts as one, anything above the cell count as the cell count.
    always_comb begin
        cap_eff = (r_capacity == '0) ? CMP_W'(1) : CMP_W'(r_capacity);
        if (cap_eff > CMP_W'(DEPTH)) begin
            cap_eff = CMP_W'(DEPTH);
        end
    end

    assign occ_ext  = CMP_W'(r_occ);
    assign is_empty = (r_occ == '0);
    assign is_full  = (occ_ext >= cap_eff);

    always_comb begin
        rear_word = '0;
        for (int i = 0; i < DEPTH; i++) begin
            rear_word = rear_word | cell_tap[i];
        end
    end

    always_comb begin
        ctl        = '0;
        ctl.clear  = i_cfg_wen;
        n_occ      = r_occ;
        res_data   = NO_WORD;
        res_status = ST_OK;
        case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
                if (is_full) begin
                    res_status = ST_FULL;
                end else begin
                    ctl.push_front = accept && (cmd == CMD_PUSH_FRONT);
                    ctl.push_rear  = accept && (cmd == CMD_PUSH_REAR);
                    n_occ          = r_occ + OCC_W'(1);
                end
            end
            CMD_POP_FRONT, CMD_POP_REAR, CMD_PEEK_FRONT, CMD_PEEK_REAR: begin
                if (is_empty) begin
                    res_status = ST_EMPTY;
                end else begin
                    if (cmd == CMD_POP_FRONT || cmd == CMD_PEEK_FRONT) begin
                        res_data = cell_data[0];
                    end else begin
                        res_data = rear_word;
                    end
                    if (cmd == CMD_POP_FRONT || cmd == CMD_POP_REAR) begin
                        ctl.pop_front = accept && (cmd == CMD_POP_FRONT);
                        ctl.pop_rear  = accept && (cmd == CMD_POP_REAR);
                        n_occ         = r_occ - OCC_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign n_occ_ext = CMP_W'(n_occ);

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_word left_data;
        logic  left_valid;
        t_word right_data;
        logic  right_valid;

        if (g == 0) begin : g_first
            assign left_data  = i_s_axis_tdata;
            assign left_valid = 1'b1;
        end else begin : g_mid_l
            assign left_data  = cell_data[g-1];
            assign left_valid = cell_valid[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right_data  = '0;
            assign right_valid = 1'b0;
        end else begin : g_mid_r
            assign right_data  = cell_data[g+1];
            assign right_valid = cell_valid[g+1];
        end

        cdq_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (ctl),
            .i_value       (i_s_axis_tdata),
            .i_left_data   (left_data),
            .i_left_valid  (left_valid),
            .i_right_data  (right_data),
            .i_right_valid (right_valid),
            .o_data        (cell_data[g]),
            .o_valid       (cell_valid[g]),
            .o_rear_tap    (cell_tap[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= CAP_RESET;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wen) begin
                r_capacity <= i_cfg_wdata;
                r_occ      <= '0;
            end else if (accept) begin
                r_occ <= n_occ;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data   <= res_data;
            r_out_status <= res_status;
            r_out_empty  <= (n_occ == '0);
            r_out_full   <= (n_occ_ext >= cap_eff);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = {r_out_full, r_out_empty, r_out_status};

endmodule

@@ rtl/cdq_checker.sv @@
module cdq_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    input  logic [31:0]  o_m_axis_tdata,
    input  logic [3:0]   o_m_axis_tuser
);
    import cdq_pkg::*;

    // A held result must not change until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    // A refused push leaves the deque full.
    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser[1:0] == ST_FULL) |-> o_m_axis_tuser[3])
        else $error("full status without full flag");

    // A refused pop or peek returns no word and leaves the deque empty.
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser[1:0] == ST_EMPTY) |->
            o_m_axis_tuser[2] && (o_m_axis_tdata == NO_WORD))
        else $error("empty status with a word or without empty flag");

    // Capacity is at least one, so the deque is never empty and full at once.
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tuser[2] && o_m_axis_tuser[3]))
        else $error("empty and full flags both set");

endmodule

bind circular_deque_core cdq_checker u_cdq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

@@ bench/tb_circular_deque_core.sv @@
module tb_circular_deque_core;
    timeunit 1ns;
    timeprecision 1ps;

    import cdq_pkg::*;

    localparam int unsigned LONG_HOLD  = 200;
    localparam int unsigned STALL_MAX  = 12;
    localparam int unsigned WATCH_LIMIT = 1000;
    localparam int unsigned PHASE_ITEMS = 117;

    // Command codes the block must treat as no-ops.
    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    localparam t_word WORD_MIN = 32'h8000_0000;
    localparam t_word WORD_MAX = 32'h7FFF_FFFF;

    typedef struct packed {
        t_word   data;
        t_status status;
        logic    now_empty;
        logic    now_full;
    } t_deque_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              cfg_wen;
    logic [CAP_W-1:0]  cfg_wdata;
    logic              s_tvalid;
    logic              s_tready;
    logic [31:0]       s_tdata;    // value[31:0]
    logic [2:0]        s_tuser;    // command[2:0]
    logic              m_tvalid;
    logic              m_tready;
    logic [31:0]       m_tdata;    // data[31:0]
    logic [3:0]        m_tuser;    // status[1:0], now_empty, now_full

    // Shadow of the deque, updated as each request is accepted.
    t_word             dq_words [DEPTH_DEF];
    logic [3:0]        dq_head;
    logic [3:0]        dq_tail;
    logic [4:0]        dq_count;
    logic [CAP_W-1:0]  dq_capacity;

    t_deque_result     pending_results [$];
    t_deque_result     oldest;
    int unsigned       error_count;
    int unsigned       quiet_cycles;
    logic              send_idle;
    logic              recv_idle;
    logic              long_hold_req;

    circular_deque_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wen       (cfg_wen),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_deque_result predict_deque(input logic [CMD_W-1:0] cmd,
                                                    input t_word value);
        t_deque_result r;
        logic [4:0]    lim;
        logic          front;
        lim = (dq_capacity == 0) ? 5'd1
            : (dq_capacity > DEPTH_DEF) ? 5'(DEPTH_DEF) : dq_capacity;
        r.data   = NO_WORD;
        r.status = ST_OK;
        front    = (cmd == CMD_POP_FRONT) || (cmd == CMD_PEEK_FRONT);
        case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
                if (dq_count >= lim) begin
                    r.status = ST_FULL;
                end else begin
                    if (dq_count == 0) begin
                        dq_head = '0;
                        dq_tail = '0;
                    end else if (cmd == CMD_PUSH_FRONT) begin
                        dq_head = (dq_head == 0) ? 4'(lim - 1) : dq_head - 4'd1;
                    end else begin
                        dq_tail = ({1'b0, dq_tail} + 5'd1 >= lim) ? 4'd0 : dq_tail + 4'd1;
                    end
                    dq_words[(cmd == CMD_PUSH_FRONT) ? dq_head : dq_tail] = value;
                    dq_count++;
                end
            end
            CMD_POP_FRONT, CMD_POP_REAR, CMD_PEEK_FRONT, CMD_PEEK_REAR: begin
                if (dq_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.data = dq_words[front ? dq_head : dq_tail];
                    if (cmd == CMD_POP_FRONT || cmd == CMD_POP_REAR) begin
                        dq_count--;
                        if (dq_count == 0) begin
                            dq_head = '0;
                            dq_tail = '0;
                        end else if (front) begin
                            dq_head = ({1'b0, dq_head} + 5'd1 >= lim) ? 4'd0
                                                                      : dq_head + 4'd1;
                        end else begin
                            dq_tail = (dq_tail == 0) ? 4'(lim - 1) : dq_tail - 4'd1;
                        end
                    end
                end
            end
            default: ;
        endcase
        r.now_empty = (dq_count == 0);
        r.now_full  = (dq_count >= lim);
        return r;
    endfunction

    function automatic t_word draw_word();
        case ($urandom_range(0, 15))
            0:       return WORD_MIN;
            1:       return WORD_MAX;
            2:       return '0;
            3:       return '1;
            default: return $urandom();
        endcase
    endfunction

    // push_pct steers the deque toward full (high) or toward empty (low).
    function automatic logic [CMD_W-1:0] draw_command(input int unsigned push_pct);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll == 0) return CMD_SPARE_6;
        if (roll == 1) return CMD_SPARE_7;
        if (roll < push_pct) return $urandom_range(0, 1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
        case ($urandom_range(0, 3))
            0:       return CMD_POP_FRONT;
            1:       return CMD_POP_REAR;
            2:       return CMD_PEEK_FRONT;
            default: return CMD_PEEK_REAR;
        endcase
    endfunction

    task automatic send_request(input logic [CMD_W-1:0] cmd, input t_word value);
        int unsigned gap;
        gap = send_idle ? $urandom_range(0, STALL_MAX) : 0;
        if (gap != 0) begin
            @(negedge i_clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= cmd;
        do @(posedge i_clk); while (!s_tready);
        pending_results.push_back(predict_deque(cmd, value));
    endtask

    task automatic release_input();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        release_input();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= cap;
        @(negedge i_clk);
        cfg_wen   <= 1'b0;
        dq_capacity = cap;
        dq_head     = '0;
        dq_tail     = '0;
        dq_count    = '0;
    endtask

    task automatic test_empty_refusals();
        send_request(CMD_POP_FRONT, draw_word());
        send_request(CMD_PEEK_REAR, draw_word());
    endtask

    task automatic test_both_ends();
        send_request(CMD_PUSH_FRONT, WORD_MIN);
        send_request(CMD_PUSH_REAR, WORD_MAX);
        send_request(CMD_PUSH_FRONT, '0);
        send_request(CMD_PUSH_REAR, '1);
        send_request(CMD_PEEK_FRONT, '0);
        send_request(CMD_PEEK_REAR, '0);
        send_request(CMD_POP_FRONT, '1);
        send_request(CMD_POP_REAR, '1);
    endtask

    task automatic test_spare_commands();
        send_request(CMD_SPARE_6, '1);
        send_request(CMD_SPARE_7, WORD_MAX);
    endtask

    // A capacity of one fills on the first push; zero must behave the same.
    task automatic test_tiny_capacity();
        set_capacity(5'd1);
        send_request(CMD_PUSH_REAR, 32'h1234_5678);
        send_request(CMD_PUSH_FRONT, 32'hDEAD_BEEF);
        send_request(CMD_PEEK_REAR, '0);
        send_request(CMD_POP_FRONT, '0);
        send_request(CMD_POP_REAR, '0);
        set_capacity(5'd0);
        send_request(CMD_PUSH_FRONT, 32'hA5A5_5A5A);
        send_request(CMD_PUSH_REAR, 32'h5A5A_A5A5);
    endtask

    // The sink stops for a long stretch while requests keep coming, so the
    // block has to hold its result and stall its input.
    task automatic test_input_stall();
        set_capacity(5'd16);
        send_idle     = 1'b0;
        long_hold_req = 1'b1;
        for (int i = 0; i < 60; i++) begin
            send_request(draw_command(i < 30 ? 75 : 25), draw_word());
        end
        send_idle = 1'b1;
    endtask

    task automatic test_random_phases();
        logic [CAP_W-1:0] caps [10];
        int unsigned      run_left;
        int unsigned      push_pct;
        caps = '{5'd16, 5'd2, 5'd31, 5'd3, 5'd17, 5'd1, 5'd8, 5'd0, 5'd16,
                 5'($urandom_range(1, 31))};
        foreach (caps[p]) begin
            set_capacity(caps[p]);
            run_left = 0;
            push_pct = 70;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i % 40 == 0) begin
                    send_idle = ($urandom_range(0, 3) != 0);
                    recv_idle = ($urandom_range(0, 3) != 0);
                end
                if (run_left == 0) begin
                    push_pct = (push_pct > 50) ? 25 : 70;
                    run_left = $urandom_range(1, 40);
                end
                run_left--;
                send_request(draw_command(push_pct), draw_word());
            end
        end
        send_idle = 1'b1;
        recv_idle = 1'b1;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        cfg_wen       = 1'b0;
        cfg_wdata     = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        send_idle     = 1'b1;
        recv_idle     = 1'b1;
        long_hold_req = 1'b0;
        error_count   = 0;
        dq_capacity   = CAP_RESET;
        dq_head       = '0;
        dq_tail       = '0;
        dq_count      = '0;
        foreach (dq_words[k]) dq_words[k] = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_refusals();
        test_both_ends();
        test_spare_commands();
        test_tiny_capacity();
        test_input_stall();
        test_random_phases();

        release_input();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin : result_sink
        int unsigned stall;
        m_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = recv_idle ? $urandom_range(0, STALL_MAX) : 0;
            if (long_hold_req) begin
                stall         = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (stall != 0) begin
                @(negedge i_clk);
                m_tready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!m_tvalid);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding");
                error_count++;
            end else begin
                oldest = pending_results.pop_front();
                if (m_tdata !== oldest.data) begin
                    $error("data: expected %08h, got %08h", oldest.data, m_tdata);
                    error_count++;
                end
                if (m_tuser[1:0] !== oldest.status) begin
                    $error("status: expected %0d, got %0d", oldest.status, m_tuser[1:0]);
                    error_count++;
                end
                if (m_tuser[2] !== oldest.now_empty) begin
                    $error("now_empty: expected %0b, got %0b", oldest.now_empty, m_tuser[2]);
                    error_count++;
                end
                if (m_tuser[3] !== oldest.now_full) begin
                    $error("now_full: expected %0b, got %0b", oldest.now_full, m_tuser[3]);
                    error_count++;
                end
            end
        end
    end

    // Counts cycles in which neither side moves a request or a result.
    initial quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCH_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

endmodule
